// ===== rtl/rtjm_pkg.sv =====
// Shared types, constants and helpers for the response time jitter monitor.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package rtjm_pkg;

   // Field widths
   localparam int TIME_W   = 32;
   localparam int SUM_W    = 48;
   localparam int CNT_W    = 16;
   localparam int TASK_W   = 4;
   localparam int IDX_W    = 9;   // wide enough to compare against up to 256 tasks
   localparam int ALU_W    = 48;
   localparam int DIVCNT_W = 6;   // counts the 48 quotient bits

   // Defaults for the top-level parameters
   localparam int DEF_MAX_TASKS = 16;
   localparam int DEF_MAX_JOBS  = 65535;

   // One task's statistics bank
   typedef struct packed {
      logic [TIME_W-1:0] min_resp;
      logic [TIME_W-1:0] max_resp;
      logic [TIME_W-1:0] first_resp;
      logic [TIME_W-1:0] prev_resp;
      logic [TIME_W-1:0] delta;
      logic [SUM_W-1:0]  sum;
      logic [CNT_W-1:0]  count;
   } bank_type;

   // Shared add/subtract unit request and response
   typedef struct packed {
      logic [ALU_W-1:0] a;
      logic [ALU_W-1:0] b;
      logic             sub;
   } alu_req_type;

   typedef struct packed {
      logic [ALU_W-1:0] res;
      logic             borrow;
   } alu_rsp_type;

   // Sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LOAD,
      ST_MIN,
      ST_MAX,
      ST_DCMP,
      ST_DSUB,
      ST_DELTA,
      ST_SUM,
      ST_STORE,
      ST_WCMP,
      ST_WSUB,
      ST_REL,
      ST_ABS,
      ST_DIV,
      ST_DONE
   } state_type;

   // Value of a bank that is empty
   function automatic bank_type bank_reset();
      bank_type b;
      b.min_resp   = '1;
      b.max_resp   = '0;
      b.first_resp = '0;
      b.prev_resp  = '0;
      b.delta      = '0;
      b.sum        = '0;
      b.count      = '0;
      return b;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/rtjm_alu.sv =====
// Shared 48-bit add/subtract unit with borrow flag, used for every compare,
// difference, accumulate and division step. Depends on rtjm_pkg.
`default_nettype none

module rtjm_alu
   import rtjm_pkg::*;
(
   input  alu_req_type alu_req,
   output alu_rsp_type alu_rsp
);

   logic [ALU_W-1:0] b_op;
   logic [ALU_W:0]   total;

   // a + b, or a + ~b + 1 for subtract
   assign b_op  = alu_req.sub ? ~alu_req.b : alu_req.b;
   assign total = {1'b0, alu_req.a} + {1'b0, b_op} + {{ALU_W{1'b0}}, alu_req.sub};

   assign alu_rsp.res    = total[ALU_W-1:0];
   assign alu_rsp.borrow = alu_req.sub & ~total[ALU_W];

endmodule

`default_nettype wire

// ===== rtl/rtjm_bank_mem.sv =====
// Per-task statistics memory: one write port, one registered read port, and a
// valid bit per entry so that an empty entry reads as a cleared bank. Uses rtjm_pkg.
`default_nettype none

module rtjm_bank_mem
   import rtjm_pkg::*;
#(
   parameter int DEPTH  = DEF_MAX_TASKS,
   parameter int ADDR_W = 4
)(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic [ADDR_W-1:0] rd_addr,
   input  wire logic              wr_en,
   input  wire logic              wr_clear,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  bank_type               wr_data,
   output bank_type               rd_bank
);

   bank_type          mem [DEPTH];
   bank_type          rd_data_ff;
   logic              rd_valid_ff;
   logic [DEPTH-1:0]  valid_ff;

   // Storage array and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff  <= mem[rd_addr];
      rd_valid_ff <= valid_ff[rd_addr];
   end

   // Entry valid bits; a clear write drops the entry back to its empty value
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= ~wr_clear;
      end
   end

   assign rd_bank = rd_valid_ff ? rd_data_ff : bank_reset();

endmodule

`default_nettype wire

// ===== rtl/response_time_jitter_monitor_unit.sv =====
// Response time jitter monitor, top level. Each accepted transaction is one
// completed job; the block keeps min, max, first, previous, largest step,
// sum and count of response times per task and, on a task's last job,
// returns max, min, absolute jitter, relative jitter (wrap from first to last
// included) and the truncated average, then empties that task's bank. A job
// runs through load, min, max, step, sum and store states before ready
// returns; a job whose task index is out of range is dropped at acceptance,
// one on a full bank after the load (a last job still stores and reports);
// a last job adds the jitter steps and the bit-serial average division. All
// steps run one after another through a single 48-bit add/subtract unit, and
// the bank memory gives one read and at most one write per transaction. A
// finished report sits in an output register, so the next job is taken while
// it waits. Depends on rtjm_pkg, rtjm_alu and rtjm_bank_mem.
`default_nettype none

module response_time_jitter_monitor_unit
   import rtjm_pkg::*;
#(
   parameter int MAX_TASKS = DEF_MAX_TASKS,
   parameter int MAX_JOBS  = DEF_MAX_JOBS
)(
   input  wire logic              clock,
   input  wire logic              reset,
   // Job transactions
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic [TASK_W-1:0] req_task_index,
   input  wire logic [TIME_W-1:0] req_arrival_time,
   input  wire logic [TIME_W-1:0] req_finish_time,
   input  wire logic              req_last_job,
   // Report transactions
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic [TASK_W-1:0]      rsp_report_task,
   output logic [TIME_W-1:0]      rsp_max_response,
   output logic [TIME_W-1:0]      rsp_min_response,
   output logic [TIME_W-1:0]      rsp_absolute_jitter,
   output logic [TIME_W-1:0]      rsp_relative_jitter,
   output logic [TIME_W-1:0]      rsp_average_response
);

   localparam int              AddrW     = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
   localparam logic [IDX_W-1:0] TaskLimit = IDX_W'(MAX_TASKS);
   localparam logic [CNT_W-1:0] JobLimit  = CNT_W'(MAX_JOBS);
   localparam logic [DIVCNT_W-1:0] DivLast = DIVCNT_W'(SUM_W - 1);

   state_type           state_ff, state_in;
   logic [TASK_W-1:0]   task_ff, task_in;
   logic [AddrW-1:0]    addr_ff, addr_in;
   logic [TIME_W-1:0]   arrival_ff, arrival_in;
   logic [TIME_W-1:0]   finish_ff, finish_in;
   logic                last_ff, last_in;
   logic [TIME_W-1:0]   resp_ff, resp_in;
   bank_type            bank_ff, bank_in;
   logic [TIME_W-1:0]   tmp_ff, tmp_in;
   logic                swap_ff, swap_in;
   logic [TIME_W-1:0]   rel_ff, rel_in;
   logic [TIME_W-1:0]   absj_ff, absj_in;
   logic [SUM_W-1:0]    num_ff, num_in;
   logic [CNT_W-1:0]    rem_ff, rem_in;
   logic [TIME_W-1:0]   quo_ff, quo_in;
   logic [DIVCNT_W-1:0] div_cnt_ff, div_cnt_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [TASK_W-1:0]   rsp_task_ff, rsp_task_in;
   logic [TIME_W-1:0]   rsp_max_ff, rsp_max_in;
   logic [TIME_W-1:0]   rsp_min_ff, rsp_min_in;
   logic [TIME_W-1:0]   rsp_absj_ff, rsp_absj_in;
   logic [TIME_W-1:0]   rsp_rel_ff, rsp_rel_in;
   logic [TIME_W-1:0]   rsp_avg_ff, rsp_avg_in;

   logic [IDX_W-1:0]    req_idx_wide;
   logic                req_in_range;
   logic [AddrW-1:0]    req_addr;
   logic [CNT_W:0]      div_trial;

   alu_req_type         alu_req;
   alu_rsp_type         alu_rsp;
   bank_type            rd_bank;
   logic                wr_en;
   logic                wr_clear;

   // Task index decode
   assign req_idx_wide = {{(IDX_W - TASK_W){1'b0}}, req_task_index};
   assign req_in_range = req_idx_wide < TaskLimit;
   assign req_addr     = req_idx_wide[AddrW-1:0];
   assign div_trial    = {rem_ff, num_ff[SUM_W-1]};

   rtjm_alu u_alu (
      .alu_req (alu_req),
      .alu_rsp (alu_rsp)
   );

   rtjm_bank_mem #(
      .DEPTH  (MAX_TASKS),
      .ADDR_W (AddrW)
   ) u_bank_mem (
      .clock    (clock),
      .reset    (reset),
      .rd_addr  (req_addr),
      .wr_en    (wr_en),
      .wr_clear (wr_clear),
      .wr_addr  (addr_ff),
      .wr_data  (bank_ff),
      .rd_bank  (rd_bank)
   );

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      task_ff     <= task_in;
      addr_ff     <= addr_in;
      arrival_ff  <= arrival_in;
      finish_ff   <= finish_in;
      last_ff     <= last_in;
      resp_ff     <= resp_in;
      bank_ff     <= bank_in;
      tmp_ff      <= tmp_in;
      swap_ff     <= swap_in;
      rel_ff      <= rel_in;
      absj_ff     <= absj_in;
      num_ff      <= num_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      div_cnt_ff  <= div_cnt_in;
      rsp_task_ff <= rsp_task_in;
      rsp_max_ff  <= rsp_max_in;
      rsp_min_ff  <= rsp_min_in;
      rsp_absj_ff <= rsp_absj_in;
      rsp_rel_ff  <= rsp_rel_in;
      rsp_avg_ff  <= rsp_avg_in;
   end

   // Sequencer: next state, datapath updates and shared unit operands
   always_comb begin
      state_in     = state_ff;
      task_in      = task_ff;
      addr_in      = addr_ff;
      arrival_in   = arrival_ff;
      finish_in    = finish_ff;
      last_in      = last_ff;
      resp_in      = resp_ff;
      bank_in      = bank_ff;
      tmp_in       = tmp_ff;
      swap_in      = swap_ff;
      rel_in       = rel_ff;
      absj_in      = absj_ff;
      num_in       = num_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      div_cnt_in   = div_cnt_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      rsp_task_in  = rsp_task_ff;
      rsp_max_in   = rsp_max_ff;
      rsp_min_in   = rsp_min_ff;
      rsp_absj_in  = rsp_absj_ff;
      rsp_rel_in   = rsp_rel_ff;
      rsp_avg_in   = rsp_avg_ff;
      req_ready    = 1'b0;
      wr_en        = 1'b0;
      wr_clear     = 1'b0;
      alu_req.a    = '0;
      alu_req.b    = '0;
      alu_req.sub  = 1'b1;

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               task_in    = req_task_index;
               addr_in    = req_addr;
               arrival_in = req_arrival_time;
               finish_in  = req_finish_time;
               last_in    = req_last_job;
               state_in   = req_in_range ? ST_LOAD : ST_IDLE;
            end
         end
         // Bank arrives from memory; response = finish - arrival, floored at 0
         ST_LOAD: begin
            alu_req.a = ALU_W'(finish_ff);
            alu_req.b = ALU_W'(arrival_ff);
            resp_in   = alu_rsp.borrow ? '0 : alu_rsp.res[TIME_W-1:0];
            bank_in   = rd_bank;
            // full bank: job dropped, a last job still reports and clears
            if (rd_bank.count >= JobLimit) begin
               state_in = last_ff ? ST_STORE : ST_IDLE;
            end else begin
               state_in = ST_MIN;
            end
         end
         ST_MIN: begin
            alu_req.a = ALU_W'(resp_ff);
            alu_req.b = ALU_W'(bank_ff.min_resp);
            if (alu_rsp.borrow) begin
               bank_in.min_resp = resp_ff;
            end
            state_in = ST_MAX;
         end
         ST_MAX: begin
            alu_req.a = ALU_W'(bank_ff.max_resp);
            alu_req.b = ALU_W'(resp_ff);
            if (alu_rsp.borrow) begin
               bank_in.max_resp = resp_ff;
            end
            state_in = ST_DCMP;
         end
         // |resp - prev| as compare then ordered subtract
         ST_DCMP: begin
            alu_req.a = ALU_W'(resp_ff);
            alu_req.b = ALU_W'(bank_ff.prev_resp);
            swap_in   = alu_rsp.borrow;
            state_in  = ST_DSUB;
         end
         ST_DSUB: begin
            alu_req.a = ALU_W'(swap_ff ? bank_ff.prev_resp : resp_ff);
            alu_req.b = ALU_W'(swap_ff ? resp_ff : bank_ff.prev_resp);
            tmp_in    = alu_rsp.res[TIME_W-1:0];
            state_in  = ST_DELTA;
         end
         ST_DELTA: begin
            alu_req.a = ALU_W'(bank_ff.delta);
            alu_req.b = ALU_W'(tmp_ff);
            if (bank_ff.count == '0) begin
               bank_in.first_resp = resp_ff;
            end else if (alu_rsp.borrow) begin
               bank_in.delta = tmp_ff;
            end
            bank_in.prev_resp = resp_ff;
            state_in = ST_SUM;
         end
         ST_SUM: begin
            alu_req.a     = ALU_W'(bank_ff.sum);
            alu_req.b     = ALU_W'(resp_ff);
            alu_req.sub   = 1'b0;
            bank_in.sum   = alu_rsp.res[SUM_W-1:0];
            bank_in.count = bank_ff.count + 1'b1;
            state_in      = ST_STORE;
         end
         // Write back, or empty the entry when the task reports
         ST_STORE: begin
            wr_en    = 1'b1;
            wr_clear = last_ff;
            state_in = last_ff ? ST_WCMP : ST_IDLE;
         end
         // Wrap step |first - prev|
         ST_WCMP: begin
            alu_req.a = ALU_W'(bank_ff.first_resp);
            alu_req.b = ALU_W'(bank_ff.prev_resp);
            swap_in   = alu_rsp.borrow;
            state_in  = ST_WSUB;
         end
         ST_WSUB: begin
            alu_req.a = ALU_W'(swap_ff ? bank_ff.prev_resp : bank_ff.first_resp);
            alu_req.b = ALU_W'(swap_ff ? bank_ff.first_resp : bank_ff.prev_resp);
            tmp_in    = alu_rsp.res[TIME_W-1:0];
            state_in  = ST_REL;
         end
         ST_REL: begin
            alu_req.a = ALU_W'(bank_ff.delta);
            alu_req.b = ALU_W'(tmp_ff);
            rel_in    = alu_rsp.borrow ? tmp_ff : bank_ff.delta;
            state_in  = ST_ABS;
         end
         // Absolute jitter, and set up the divider
         ST_ABS: begin
            alu_req.a  = ALU_W'(bank_ff.max_resp);
            alu_req.b  = ALU_W'(bank_ff.min_resp);
            absj_in    = alu_rsp.res[TIME_W-1:0];
            num_in     = bank_ff.sum;
            rem_in     = '0;
            quo_in     = '0;
            div_cnt_in = '0;
            state_in   = ST_DIV;
         end
         // Restoring division, one quotient bit per cycle; upper bits fall off
         ST_DIV: begin
            alu_req.a  = ALU_W'(div_trial);
            alu_req.b  = ALU_W'(bank_ff.count);
            rem_in     = alu_rsp.borrow ? div_trial[CNT_W-1:0] : alu_rsp.res[CNT_W-1:0];
            quo_in     = {quo_ff[TIME_W-2:0], ~alu_rsp.borrow};
            num_in     = {num_ff[SUM_W-2:0], 1'b0};
            div_cnt_in = div_cnt_ff + 1'b1;
            if (div_cnt_ff == DivLast) begin
               state_in = ST_DONE;
            end
         end
         // Hand the report to the output register once it is free
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_task_in  = task_ff;
               rsp_max_in   = bank_ff.max_resp;
               rsp_min_in   = bank_ff.min_resp;
               rsp_absj_in  = absj_ff;
               rsp_rel_in   = rel_ff;
               rsp_avg_in   = (bank_ff.count == '0) ? '0 : quo_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_report_task      = rsp_task_ff;
   assign rsp_max_response     = rsp_max_ff;
   assign rsp_min_response     = rsp_min_ff;
   assign rsp_absolute_jitter  = rsp_absj_ff;
   assign rsp_relative_jitter  = rsp_rel_ff;
   assign rsp_average_response = rsp_avg_ff;

`ifndef SYNTH
   // Absolute jitter is consistent with the reported extremes
   assert_absj: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_absj_ff == rsp_max_ff - rsp_min_ff))
      else $error("absolute jitter differs from max minus min");

   // No step between responses can exceed the full spread
   assert_rel_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_rel_ff <= rsp_absj_ff))
      else $error("relative jitter exceeds absolute jitter");

   // The average lies between the extremes
   assert_avg_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_avg_ff >= rsp_min_ff && rsp_avg_ff <= rsp_max_ff))
      else $error("average response outside min/max");

   // A new report only comes out of the final sequencer step
   assert_rsp_src: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_DONE))
      else $error("report raised outside the final step");
`endif

endmodule

`default_nettype wire
